/* src/ltvrp_pkg.sv */
// ============================================================================
// ltvrp_pkg
// Shared types and codes for the length-type-value record parser.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ltvrp_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Result queue sizing: one item may push two words.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_TYPE,
    PH_VALUE,
    PH_SWALLOW
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] blob_len;
    logic [7:0] data_byte;
  } ltvrp_in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] entry_type;
    logic [7:0] value_byte;
    logic [7:0] value_index;
    logic       entry_end;
    logic       run_last;
  } ltvrp_out_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] blob_left;
    logic [7:0] rec_left;
    logic [7:0] cur_type;
    logic [7:0] val_pos;
    logic       cur_dup;
  } ltvrp_state_t;

  typedef struct packed {
    logic clear;
    logic set;
  } ltvrp_seen_ctl_t;

  typedef struct packed {
    logic [1:0] count;
    ltvrp_out_t word0;
    ltvrp_out_t word1;
  } ltvrp_res_t;

endpackage

`default_nettype wire

/* src/ltvrp_seen.sv */
// ============================================================================
// ltvrp_seen
// Store of record types already met in the current blob.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ltvrp_seen
  import ltvrp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            look,
  input  wire logic [7:0]      look_addr,
  input  wire logic            start_held,
  input  wire logic            en,
  input  wire ltvrp_seen_ctl_t ctl,
  input  wire logic [7:0]      addr,
  output logic                 hit,
  output logic                 busy
);

  // Each entry holds the number of the blob that last met its type, so a
  // start word only has to step the blob number. Number zero is never used
  // by a blob and is what the clearing pass writes.
  logic [7:0] mark [256];
  logic [7:0] mark_q;
  logic [7:0] epoch;
  logic       clearing;
  logic [7:0] clr_addr;
  logic       wrap_due;

  // A start word that would wrap the blob number waits for a clearing pass.
  assign wrap_due = start_held && (epoch == 8'hFF);
  assign busy     = clearing || wrap_due;
  assign hit      = (mark_q == epoch);

  always_ff @(posedge clk) begin
    if (clearing) begin
      mark[clr_addr] <= 8'd0;
    end else if (en && ctl.set) begin
      mark[addr] <= epoch;
    end
  end

  // The entry is read as the word enters the input register. Type bytes are
  // always separated by a length byte, so the entry is never written between
  // this read and the parse that uses it.
  always_ff @(posedge clk) begin
    if (look) begin
      mark_q <= mark[look_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= 8'd0;
      clearing <= 1'b1;
      clr_addr <= 8'd0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 8'd1;
      if (clr_addr == 8'hFF) begin
        clearing <= 1'b0;
        epoch    <= 8'd0;
      end
    end else if (wrap_due) begin
      clearing <= 1'b1;
      clr_addr <= 8'd0;
    end else if (en && ctl.clear) begin
      epoch <= epoch + 8'd1;
    end
  end

endmodule

`default_nettype wire

/* src/ltvrp_step.sv */
// ============================================================================
// ltvrp_step
// Combinational parse step: one byte against the parser state.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ltvrp_step
  import ltvrp_pkg::*;
(
  input  wire ltvrp_state_t    st,
  input  wire ltvrp_in_t       item,
  input  wire logic            seen_hit,
  output ltvrp_state_t         st_next,
  output ltvrp_seen_ctl_t      seen_ctl,
  output ltvrp_res_t           res
);

  logic       p_valid;
  ltvrp_out_t p_word;
  logic       d_valid;
  ltvrp_out_t d_word;
  logic [7:0] bl;
  logic [7:0] rl;
  logic       blob_end;

  always_comb begin
    st_next        = st;
    seen_ctl       = '0;
    p_valid        = 1'b0;
    p_word         = '0;
    d_valid        = 1'b0;
    d_word         = '0;
    d_word.result_kind = KIND_DONE;
    bl             = st.blob_left - 8'd1;
    rl             = st.rec_left - 8'd1;
    blob_end       = (bl == 8'd0);

    if (item.req_type == REQ_START) begin
      seen_ctl.clear    = 1'b1;
      st_next.rec_left  = '0;
      st_next.cur_type  = '0;
      st_next.val_pos   = '0;
      st_next.cur_dup   = 1'b0;
      st_next.blob_left = item.blob_len;
      if (item.blob_len == 8'd0) begin
        st_next.phase = PH_IDLE;
        d_valid       = 1'b1;
      end else begin
        st_next.phase = PH_LEN;
      end
    end else if (st.phase != PH_IDLE && st.blob_left != 8'd0) begin
      st_next.blob_left = bl;
      unique case (st.phase)
        PH_LEN: begin
          if (item.data_byte == 8'd0) begin
            if (blob_end) begin
              st_next.phase = PH_IDLE;
              d_valid       = 1'b1;
            end
          end else if (item.data_byte > bl) begin
            p_valid            = 1'b1;
            p_word.result_kind = KIND_ERROR;
            st_next.phase      = blob_end ? PH_IDLE : PH_SWALLOW;
          end else begin
            st_next.rec_left = item.data_byte;
            st_next.phase    = PH_TYPE;
          end
        end
        PH_TYPE: begin
          st_next.cur_type = item.data_byte;
          st_next.rec_left = rl;
          st_next.cur_dup  = seen_hit;
          st_next.val_pos  = '0;
          seen_ctl.set     = 1'b1;
          if (rl == 8'd0) begin
            if (!seen_hit) begin
              p_valid            = 1'b1;
              p_word.result_kind = KIND_EMPTY;
              p_word.entry_type  = item.data_byte;
            end
            st_next.phase = PH_LEN;
          end else begin
            st_next.phase = PH_VALUE;
          end
          if (blob_end) begin
            st_next.phase = PH_IDLE;
            d_valid       = 1'b1;
          end
        end
        PH_VALUE: begin
          if (!st.cur_dup) begin
            p_valid            = 1'b1;
            p_word.result_kind = KIND_VALUE;
            p_word.entry_type  = st.cur_type;
            p_word.value_byte  = item.data_byte;
            p_word.value_index = st.val_pos;
            p_word.entry_end   = (st.rec_left == 8'd1);
          end
          st_next.val_pos  = st.val_pos + 8'd1;
          st_next.rec_left = rl;
          if (rl == 8'd0) begin
            st_next.phase = PH_LEN;
          end
          if (blob_end) begin
            st_next.phase = PH_IDLE;
            d_valid       = 1'b1;
          end
        end
        default: begin
          if (blob_end) begin
            st_next.phase = PH_IDLE;
          end
        end
      endcase
    end else begin
      st_next.phase = PH_IDLE;
    end

    // Pack the results: the record result, if any, goes ahead of done.
    p_word.run_last   = !d_valid;
    d_word.run_last   = 1'b1;
    res.count         = {1'b0, p_valid} + {1'b0, d_valid};
    res.word0         = p_valid ? p_word : d_word;
    res.word1         = d_word;
  end

endmodule

`default_nettype wire

/* src/ltvrp_res_fifo.sv */
// ============================================================================
// ltvrp_res_fifo
// Small queue taking up to two results a cycle, giving one if not stalled.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ltvrp_res_fifo
  import ltvrp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ltvrp_res_t           res,
  output logic [RES_CNT_W-1:0]      count,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output ltvrp_out_t                result
);

  ltvrp_out_t           mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [1:0]           push_n;
  logic                 pop;

  assign push_n       = push ? res.count : 2'd0;
  assign result_valid = (count != '0);
  assign pop          = result_valid && !result_stall;
  assign result       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= res.word0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= res.word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push_n);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop);
      count  <= count + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* src/ltvrp_record_parser_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ltv_record_parser_core
// Length-type-value record parser taking one blob byte per word.
// ============================================================================
// The parser takes one word per clock cycle unless it stalls. A start word
// opens a blob of the given length, and data words carry its bytes in order.
// Every value byte of a record comes out tagged with its type and index, a
// record with no value gives one empty-entry word, a record whose type has
// already been seen in the blob is consumed silently, and a good blob closes
// with a done word. A length byte that overruns the blob gives an error word
// at once and the rest of the blob is swallowed. An accepted word is held in
// an input register, is parsed there by a single combinational step, and
// its results (none, one or two) are written into a four-word result queue
// as the register moves on. The input register moves on whenever the queue
// has room for two words and the seen-type store is neither clearing nor
// waiting to clear, so words are taken back to back while the consumer
// keeps up; a data word that gives two results (an empty record or a value
// byte that closes the blob) sends two words through the output port, and
// the queue depth sets how far such bursts can run ahead of the consumer.
// The run_last flag marks the final result of each input word. The seen-type
// store is a 256-entry memory that holds, for each type, the number of the
// blob that last met it, so a start word only steps the blob number. The
// store is cleared by a pass over all its entries after reset, during which
// no word is parsed, and again when the blob number would wrap: the 256th
// start word after each pass is held while the store is cleared.
// ============================================================================

module ltv_record_parser_core
  import ltvrp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire ltvrp_in_t  item,
  output logic            result_valid,
  input  wire logic       result_stall,
  output ltvrp_out_t      result
);

  // Input register.
  ltvrp_in_t    item_q;
  logic         item_q_valid;
  logic         item_q_valid_next;
  logic         accept;
  logic         advance;

  // Parser state and step outputs.
  ltvrp_state_t    st;
  ltvrp_state_t    st_next;
  ltvrp_seen_ctl_t seen_ctl;
  ltvrp_res_t      res;
  logic            seen_hit;
  logic            seen_busy;
  logic            start_held;

  logic [RES_CNT_W-1:0] res_count;

  // The held word is parsed once the queue can take two more words and the
  // seen-type store is ready. Both conditions come from registers, so stall
  // does not depend on the consumer's stall within the same cycle.
  assign start_held = item_q_valid && (item_q.req_type == REQ_START);
  assign advance    = item_q_valid && !seen_busy &&
                      (res_count <= RES_CNT_W'(RES_DEPTH - 2));
  assign item_stall = item_q_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    item_q_valid_next = item_q_valid;
    if (accept) begin
      item_q_valid_next = 1'b1;
    end else if (advance) begin
      item_q_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else begin
      item_q_valid <= item_q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  // Parser state advances with each parsed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= PH_IDLE;
      st.blob_left <= '0;
      st.rec_left  <= '0;
      st.cur_type  <= '0;
      st.val_pos   <= '0;
      st.cur_dup   <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // The store is looked up as a word is accepted, so its answer is ready in
  // a register by the time the word is parsed.
  ltvrp_seen u_seen (
    .clk        (clk),
    .rst        (rst),
    .look       (accept),
    .look_addr  (item.data_byte),
    .start_held (start_held),
    .en         (advance),
    .ctl        (seen_ctl),
    .addr       (item_q.data_byte),
    .hit        (seen_hit),
    .busy       (seen_busy)
  );

  ltvrp_step u_step (
    .st       (st),
    .item     (item_q),
    .seen_hit (seen_hit),
    .st_next  (st_next),
    .seen_ctl (seen_ctl),
    .res      (res)
  );

  ltvrp_res_fifo u_res_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (advance),
    .res          (res),
    .count        (res_count),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the length-type-value record parser core.
// ============================================================================
// Blobs are fed one word at a time: a short directed set that walks through
// the awkward corners, then randomly shaped blobs. Most are well formed with
// random record lengths and types. Some overrun, some are cut short by the
// next start, and some are plain noise. Every accepted input word is run
// through a parse tracker that keeps its own copy of the parser state and
// queues the result words it predicts. Every result word is checked against
// the oldest prediction, one field at a time. Both handshakes idle at
// random.
// ============================================================================

module tb_top;
  import ltvrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          ITEM_TARGET = 950;
  localparam int          REPORT_CAP  = 200;

  // Shapes of randomly generated blobs.
  localparam int STYLE_CLEAN   = 0;
  localparam int STYLE_OVERRUN = 1;
  localparam int STYLE_TRUNC   = 2;
  localparam int STYLE_NOISE   = 3;
  localparam int STYLE_BIG     = 4;

  // --------------------------------------------------------------------------
  // Parse tracker: mirrors the parser state, predicts the result words for
  // each accepted input word and checks the words that come out.
  // --------------------------------------------------------------------------
  class ltv_tracker;
    phase_t     ph;
    logic [7:0] bytes_to_go;
    logic [7:0] rec_to_go;
    logic [7:0] rec_type;
    logic [7:0] val_idx;
    bit         rec_dup;
    bit         type_taken [256];
    ltvrp_out_t due [$];
    int         failures;

    function new();
      ph          = PH_IDLE;
      bytes_to_go = '0;
      rec_to_go   = '0;
      rec_type    = '0;
      val_idx     = '0;
      rec_dup     = 1'b0;
      foreach (type_taken[i]) type_taken[i] = 1'b0;
      failures    = 0;
    endfunction

    function ltvrp_out_t result_word(logic [1:0] kind, logic [7:0] etype, logic [7:0] vb,
                                     logic [7:0] idx, logic last_byte);
      ltvrp_out_t r;
      r.result_kind = kind;
      r.entry_type  = etype;
      r.value_byte  = vb;
      r.value_index = idx;
      r.entry_end   = last_byte;
      r.run_last    = 1'b0;
      return r;
    endfunction

    // Advances the tracked state by one accepted input word and queues the
    // result words that it should produce.
    function void parse_word(ltvrp_in_t w);
      logic       blob_end;
      logic [7:0] b;
      ltvrp_out_t burst [$];
      b = w.data_byte;
      if (w.req_type == REQ_START) begin
        // A start always wipes the previous blob, finished or not.
        foreach (type_taken[i]) type_taken[i] = 1'b0;
        rec_to_go   = '0;
        rec_type    = '0;
        val_idx     = '0;
        rec_dup     = 1'b0;
        bytes_to_go = w.blob_len;
        if (w.blob_len == 8'd0) begin
          ph = PH_IDLE;
          burst = {burst, result_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 1'b0)};
        end else begin
          ph = PH_LEN;
        end
      end else if (ph != PH_IDLE && bytes_to_go != 8'd0) begin
        bytes_to_go = bytes_to_go - 8'd1;
        blob_end    = (bytes_to_go == 8'd0);
        case (ph)
          PH_LEN: begin
            if (b == 8'd0) begin
              if (blob_end) begin
                ph = PH_IDLE;
                burst = {burst, result_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 1'b0)};
              end
            end else if (b > bytes_to_go) begin
              burst = {burst, result_word(KIND_ERROR, 8'd0, 8'd0, 8'd0, 1'b0)};
              ph = blob_end ? PH_IDLE : PH_SWALLOW;
            end else begin
              rec_to_go = b;
              ph        = PH_TYPE;
            end
          end
          PH_TYPE: begin
            rec_type      = b;
            rec_to_go     = rec_to_go - 8'd1;
            rec_dup       = type_taken[b];
            type_taken[b] = 1'b1;
            val_idx       = '0;
            if (rec_to_go == 8'd0) begin
              if (!rec_dup) burst = {burst, result_word(KIND_EMPTY, b, 8'd0, 8'd0, 1'b0)};
              ph = PH_LEN;
            end else begin
              ph = PH_VALUE;
            end
            if (blob_end) begin
              ph = PH_IDLE;
              burst = {burst, result_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 1'b0)};
            end
          end
          PH_VALUE: begin
            if (!rec_dup)
              burst = {burst, result_word(KIND_VALUE, rec_type, b, val_idx,
                                          rec_to_go == 8'd1)};
            val_idx   = val_idx + 8'd1;
            rec_to_go = rec_to_go - 8'd1;
            if (rec_to_go == 8'd0) ph = PH_LEN;
            if (blob_end) begin
              ph = PH_IDLE;
              burst = {burst, result_word(KIND_DONE, 8'd0, 8'd0, 8'd0, 1'b0)};
            end
          end
          default: begin
            if (blob_end) ph = PH_IDLE;
          end
        endcase
      end else begin
        ph = PH_IDLE;
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      due = {due, burst};
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        if (failures <= REPORT_CAP)
          $error("%s: expected %0d, actual %0d", field, want, got);
      end
    endfunction

    function void check_result(ltvrp_out_t got);
      ltvrp_out_t want;
      if (due.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $error("result word with nothing expected: kind %0d type %0d",
                 got.result_kind, got.entry_type);
      end else begin
        want = due.pop_front();
        compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        compare_field("entry_type",  32'(want.entry_type),  32'(got.entry_type));
        compare_field("value_byte",  32'(want.value_byte),  32'(got.value_byte));
        compare_field("value_index", 32'(want.value_index), 32'(got.value_index));
        compare_field("entry_end",   32'(want.entry_end),   32'(got.entry_end));
        compare_field("run_last",    32'(want.run_last),    32'(got.run_last));
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  ltvrp_in_t  item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  ltvrp_out_t result;

  ltv_tracker  tracker = new();
  logic [7:0]  blob_plan [$];
  int          items_sent = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  ltv_record_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Fields that a word does not use carry random values, so that
  // the parser is seen to ignore them.
  // --------------------------------------------------------------------------
  function automatic ltvrp_in_t start_word(logic [7:0] len);
    ltvrp_in_t w;
    w.req_type  = REQ_START;
    w.blob_len  = len;
    w.data_byte = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic ltvrp_in_t data_word(logic [7:0] b);
    ltvrp_in_t w;
    w.req_type  = REQ_DATA;
    w.blob_len  = 8'($urandom_range(0, 255));
    w.data_byte = b;
    return w;
  endfunction

  // Presents one word after a random gap and holds it until it is taken.
  // Valid is only lowered when a gap is actually wanted, so back-to-back
  // words never see valid dropped and raised in the same time step.
  task automatic send_word(input ltvrp_in_t w);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.parse_word(w);
  endtask

  // Opens a blob of the given length and sends the first cut bytes of the
  // planned contents.
  task automatic run_blob(input int len, input int cut);
    send_word(start_word(len[7:0]));
    for (int k = 0; k < cut; k++) send_word(data_word(blob_plan[k]));
    items_sent += 1 + cut;
  endtask

  // Appends one byte to the planned blob contents.
  function automatic void plan_add(logic [7:0] b);
    blob_plan = {blob_plan, b};
  endfunction

  // Fills blob_plan with len bytes. Types are mostly drawn from a small pool
  // so that repeated types, and hence suppressed records, turn up often.
  task automatic plan_blob(input int len, input int style);
    int left;
    int rec;
    int room;
    blob_plan = {};
    left = len;
    while (left > 0) begin
      if (style == STYLE_NOISE) begin
        plan_add(8'($urandom_range(0, 255)));
        left--;
      end else begin
        room = left - 1;
        if (style == STYLE_OVERRUN && $urandom_range(0, 2) == 0)
          rec = $urandom_range(left, 255);
        else if (style == STYLE_BIG && left == len)
          rec = room;
        else if (room == 0 || $urandom_range(0, 9) == 0)
          rec = 0;
        else if ($urandom_range(0, 7) == 0)
          rec = $urandom_range(1, room);
        else
          rec = $urandom_range(1, (room < 6) ? room : 6);
        plan_add(rec[7:0]);
        left--;
        if (rec > left) begin
          // The length overruns the blob: whatever follows is swallowed.
          repeat (left) plan_add(8'($urandom_range(0, 255)));
          left = 0;
        end else begin
          for (int k = 0; k < rec; k++) begin
            if (k > 0)
              plan_add(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 3) == 0)
              plan_add(8'($urandom_range(0, 255)));
            else
              plan_add(8'($urandom_range(0, 5)));
          end
          left -= rec;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: each accepted word is checked, then the stall is held high
  // for a randomly drawn number of cycles. Quiet stretches with no stall at
  // all come and go at random.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_valid && !result_stall) begin
          tracker.check_result(result);
          if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
          stall_left = rx_calm ? 0 : $urandom_range(0, 19);
        end else if (stall_left > 0) begin
          stall_left--;
        end
        result_stall <= (stall_left > 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int blob_no;
    int len;
    int style;
    int cut;
    int pick;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // An empty blob closes at once with a done word.
    blob_plan = {};
    run_blob(0, 0);
    // A data word with no blob open is dropped without a result.
    send_word(data_word(8'h5A));
    // A skipped zero length, an empty record of the top type, a record of
    // type zero with extreme values, a repeated type that must be suppressed,
    // and an empty record closing the blob (empty entry then done).
    blob_plan = '{8'h00, 8'h01, 8'hFF, 8'h03, 8'h00, 8'hFF, 8'h80,
                  8'h02, 8'hFF, 8'h11, 8'h01, 8'h42};
    run_blob(12, 12);
    // An overrunning length: error at once, the remaining bytes swallowed.
    blob_plan = '{8'h05, 8'hAA, 8'hBB, 8'hCC};
    run_blob(4, 4);
    // A start arriving mid-record aborts the blob silently.
    blob_plan = '{8'h03, 8'h07};
    run_blob(10, 2);
    blob_plan = '{8'h01, 8'h09};
    run_blob(2, 2);
    // An overrun on the very last byte of the blob.
    blob_plan = '{8'h02};
    run_blob(1, 1);

    blob_no = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      style = STYLE_CLEAN;
      else if (pick < 82) style = STYLE_OVERRUN;
      else if (pick < 92) style = STYLE_TRUNC;
      else                style = STYLE_NOISE;

      // Two blobs in every forty are full size: one a single record with the
      // longest possible value, the other packed with ordinary records. The rest are mostly short.
      if (blob_no % 40 == 13) begin
        len   = 255;
        style = STYLE_BIG;
      end else if (blob_no % 40 == 33) begin
        len   = 255;
        style = STYLE_CLEAN;
      end else if ($urandom_range(0, 15) == 0) begin
        len = 0;
      end else if ($urandom_range(0, 24) == 0) begin
        len = $urandom_range(25, 254);
      end else begin
        len = $urandom_range(1, 24);
      end

      plan_blob(len, style);
      cut = (style == STYLE_TRUNC && len > 0) ? $urandom_range(0, len - 1) : len;
      run_blob(len, cut);

      // Now and then a stray byte after a finished blob; it must be ignored.
      if (style != STYLE_TRUNC && $urandom_range(0, 19) == 0)
        send_word(data_word(8'($urandom_range(0, 255))));
      blob_no++;
    end
    item_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    // Give any stray late word time to surface before the verdict.
    repeat (16) @(posedge clk);
    if (tracker.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
